### rtl/core/qvr_pkg.sv
// shared types and constants for the quaternion vector rotator
`timescale 1ns / 1ps

package qvr_pkg;

    // component and register widths
    localparam int CompW  = 16;
    localparam int ProdW  = 2 * CompW;
    localparam int ElemW  = ProdW + 1;
    localparam int TermW  = CompW + ElemW;
    localparam int DotW   = TermW + 2;
    localparam int CfgIdxW = 3;

    // one half in the matrix format, signed 33 bits with 28 fractional bits
    localparam logic signed [ElemW-1:0] HalfQ28 = ElemW'(64'sd134217728);

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_QUAT_SCALAR = 3'd0,
        CFG_QUAT_AXIS_X = 3'd1,
        CFG_QUAT_AXIS_Y = 3'd2,
        CFG_QUAT_AXIS_Z = 3'd3
    } t_cfg_idx;

    // rotation matrix, member e_<out><in> multiplies input <in> into output <out>
    typedef struct packed {
        logic signed [ElemW-1:0] e_xx;
        logic signed [ElemW-1:0] e_xy;
        logic signed [ElemW-1:0] e_xz;
        logic signed [ElemW-1:0] e_yx;
        logic signed [ElemW-1:0] e_yy;
        logic signed [ElemW-1:0] e_yz;
        logic signed [ElemW-1:0] e_zx;
        logic signed [ElemW-1:0] e_zy;
        logic signed [ElemW-1:0] e_zz;
    } t_matrix;

endpackage

### rtl/core/qvr_in_if.sv
// request channel carrying one vector to rotate
`timescale 1ns / 1ps

interface qvr_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [qvr_pkg::CompW-1:0] in_x;
    logic signed [qvr_pkg::CompW-1:0] in_y;
    logic signed [qvr_pkg::CompW-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

### rtl/core/qvr_out_if.sv
// result channel carrying one rotated vector
`timescale 1ns / 1ps

interface qvr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [qvr_pkg::CompW-1:0] out_x;
    logic signed [qvr_pkg::CompW-1:0] out_y;
    logic signed [qvr_pkg::CompW-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

### rtl/core/qvr_cfg.sv
// quaternion registers and the registered rotation matrix built from them
`timescale 1ns / 1ps

module qvr_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [qvr_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [qvr_pkg::CompW-1:0]          i_cfg_data,
    output qvr_pkg::t_matrix                   o_matrix,
    output logic                               o_settled
);

    logic signed [qvr_pkg::CompW-1:0] r_qc, r_qx, r_qy, r_qz;
    logic signed [qvr_pkg::ProdW-1:0] r_cc, r_cx, r_cy, r_cz;
    logic signed [qvr_pkg::ProdW-1:0] r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;
    qvr_pkg::t_matrix                 r_matrix;
    qvr_pkg::t_matrix                 n_matrix;
    logic [1:0]                       r_settle;

    // quaternion registers, writes past the last index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qc <= qvr_pkg::CompW'(16'sd16384);
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                qvr_pkg::CFG_QUAT_SCALAR: r_qc <= i_cfg_data;
                qvr_pkg::CFG_QUAT_AXIS_X: r_qx <= i_cfg_data;
                qvr_pkg::CFG_QUAT_AXIS_Y: r_qy <= i_cfg_data;
                qvr_pkg::CFG_QUAT_AXIS_Z: r_qz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // settle count: the matrix follows the registers through the product and matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 2'd2;
        end else if (i_cfg_wen) begin
            r_settle <= 2'd2;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // ten pairwise products
    always_ff @(posedge i_clk) begin
        r_cc <= r_qc * r_qc;
        r_cx <= r_qc * r_qx;
        r_cy <= r_qc * r_qy;
        r_cz <= r_qc * r_qz;
        r_xx <= r_qx * r_qx;
        r_xy <= r_qx * r_qy;
        r_xz <= r_qx * r_qz;
        r_yy <= r_qy * r_qy;
        r_yz <= r_qy * r_qz;
        r_zz <= r_qz * r_qz;
    end

    // matrix elements from the products
    always_comb begin
        n_matrix.e_xx = qvr_pkg::ElemW'(r_cc) + qvr_pkg::ElemW'(r_xx) - qvr_pkg::HalfQ28;
        n_matrix.e_xy = qvr_pkg::ElemW'(r_xy) - qvr_pkg::ElemW'(r_cz);
        n_matrix.e_xz = qvr_pkg::ElemW'(r_xz) + qvr_pkg::ElemW'(r_cy);
        n_matrix.e_yx = qvr_pkg::ElemW'(r_xy) + qvr_pkg::ElemW'(r_cz);
        n_matrix.e_yy = qvr_pkg::ElemW'(r_cc) + qvr_pkg::ElemW'(r_yy) - qvr_pkg::HalfQ28;
        n_matrix.e_yz = qvr_pkg::ElemW'(r_yz) - qvr_pkg::ElemW'(r_cx);
        n_matrix.e_zx = qvr_pkg::ElemW'(r_xz) - qvr_pkg::ElemW'(r_cy);
        n_matrix.e_zy = qvr_pkg::ElemW'(r_yz) + qvr_pkg::ElemW'(r_cx);
        n_matrix.e_zz = qvr_pkg::ElemW'(r_cc) + qvr_pkg::ElemW'(r_zz) - qvr_pkg::HalfQ28;
    end

    always_ff @(posedge i_clk) begin
        r_matrix <= n_matrix;
    end

    assign o_matrix  = r_matrix;
    assign o_settled = (r_settle == 2'd0);

    // a register write must hold off new vectors on the next cycle
    a_wen_unsettles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wen |=> !o_settled)
        else $error("matrix reported settled right after a write");

endmodule

### rtl/core/qvr_datapath.sv
// four-stage rotation pipeline: input, products, sums, round and saturate
`timescale 1ns / 1ps

module qvr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_settled,
    input  qvr_pkg::t_matrix i_matrix,
    qvr_in_if.sink           in_ch,
    qvr_out_if.source        out_ch
);

    localparam int RndShift = 27;
    localparam int QW = qvr_pkg::DotW + 1 - RndShift;

    // round half up then clip to 16 bits
    function automatic logic signed [qvr_pkg::CompW-1:0] round_sat(
        input logic signed [qvr_pkg::DotW-1:0] dot
    );
        logic signed [qvr_pkg::DotW:0] t;
        logic signed [QW-1:0]          q;
        t = (qvr_pkg::DotW+1)'(dot) + (qvr_pkg::DotW+1)'(64'sd67108864);
        q = QW'(t >>> RndShift);
        if (q > QW'(32767)) begin
            round_sat = 16'sh7fff;
        end else if (q < -QW'(32768)) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[qvr_pkg::CompW-1:0];
        end
    endfunction

    logic ld0, ld1, ld2, ld3;
    logic r_v0, r_v1, r_v2, r_v3;

    logic signed [qvr_pkg::CompW-1:0] r_x, r_y, r_z;
    logic signed [qvr_pkg::TermW-1:0] r_pxx, r_pxy, r_pxz;
    logic signed [qvr_pkg::TermW-1:0] r_pyx, r_pyy, r_pyz;
    logic signed [qvr_pkg::TermW-1:0] r_pzx, r_pzy, r_pzz;
    logic signed [qvr_pkg::DotW-1:0]  r_dx, r_dy, r_dz;
    logic signed [qvr_pkg::CompW-1:0] r_ox, r_oy, r_oz;

    // stage loads ripple back from the output
    assign ld3 = !r_v3 || out_ch.ready;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign ld0 = !r_v0 || ld1;
    assign in_ch.ready = ld0 && i_settled;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) r_v0 <= in_ch.valid && i_settled;
            if (ld1) r_v1 <= r_v0;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (ld0) begin
            r_x <= in_ch.in_x;
            r_y <= in_ch.in_y;
            r_z <= in_ch.in_z;
        end
    end

    // nine vector-by-element products
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_pxx <= r_x * i_matrix.e_xx;
            r_pxy <= r_y * i_matrix.e_xy;
            r_pxz <= r_z * i_matrix.e_xz;
            r_pyx <= r_x * i_matrix.e_yx;
            r_pyy <= r_y * i_matrix.e_yy;
            r_pyz <= r_z * i_matrix.e_yz;
            r_pzx <= r_x * i_matrix.e_zx;
            r_pzy <= r_y * i_matrix.e_zy;
            r_pzz <= r_z * i_matrix.e_zz;
        end
    end

    // dot products per output component
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_dx <= qvr_pkg::DotW'(r_pxx) + qvr_pkg::DotW'(r_pxy) + qvr_pkg::DotW'(r_pxz);
            r_dy <= qvr_pkg::DotW'(r_pyx) + qvr_pkg::DotW'(r_pyy) + qvr_pkg::DotW'(r_pyz);
            r_dz <= qvr_pkg::DotW'(r_pzx) + qvr_pkg::DotW'(r_pzy) + qvr_pkg::DotW'(r_pzz);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_ox <= round_sat(r_dx);
            r_oy <= round_sat(r_dy);
            r_oz <= round_sat(r_dz);
        end
    end

    assign out_ch.valid = r_v3;
    assign out_ch.out_x = r_ox;
    assign out_ch.out_y = r_oy;
    assign out_ch.out_z = r_oz;

    a_hold_while_unsettled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_settled |-> !in_ch.ready)
        else $error("vector taken while matrix is being rebuilt");

    a_products_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && ld2) |=> r_v2)
        else $error("product stage item lost");

    a_sums_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && ld3) |=> r_v3)
        else $error("sum stage item lost");

endmodule

### rtl/core/quaternion_vector_rotate.sv
// top level of the quaternion vector rotator
//
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    in_x, in_y, in_z    (signed 16)
//   o_out     out   valid / ready    out_x, out_y, out_z (signed 16)
//   i_cfg_*   in    i_cfg_wen        i_cfg_idx (3), i_cfg_data (16)
//
// one vector per cycle unless o_out stalls or the matrix is being rebuilt;
// a result passes the input, product, sum and round/saturate registers
// after reset and after every register write, i_in.ready stays low
// while the product and matrix registers follow the new quaternion
// a stall at o_out backs up stage by stage; bubbles are squeezed out
`timescale 1ns / 1ps

module quaternion_vector_rotate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    qvr_in_if.sink                      i_in,
    qvr_out_if.source                   o_out,
    input  logic                        i_cfg_wen,
    input  logic [qvr_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [qvr_pkg::CompW-1:0]   i_cfg_data
);

    qvr_pkg::t_matrix matrix;
    logic             settled;

    // quaternion registers and matrix
    qvr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_matrix   (matrix),
        .o_settled  (settled)
    );

    // rotation pipeline
    qvr_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_settled (settled),
        .i_matrix  (matrix),
        .in_ch     (i_in),
        .out_ch    (o_out)
    );

endmodule
